// File: hw/rtl/sgp_pkg.sv
`timescale 1ns / 1ps

package sgp_pkg;

    localparam int LIST_ENTRIES   = 512;
    localparam int MAX_ELEM_BYTES = 131072;
    localparam int ADDR_WIDTH     = 64;

    localparam int AW         = ADDR_WIDTH;
    localparam int IN_LEN_W   = 18;
    localparam int LEN_W      = $clog2(MAX_ELEM_BYTES + 1);
    localparam int LEN_CMP_W  = (LEN_W > IN_LEN_W) ? LEN_W : IN_LEN_W;
    localparam int PG_W       = 17;
    localparam int SZ_W       = (LEN_W > PG_W) ? LEN_W : PG_W;
    localparam int CNT_W      = $clog2(LIST_ENTRIES + 1);
    localparam int IDX_W      = 9;
    localparam int PS_W       = 5;
    localparam int PS_MIN     = 12;
    localparam int PS_MAX     = 16;
    localparam int PS_RESET   = 12;

    typedef enum logic [1:0] {
        KIND_PRP1    = 2'd0,
        KIND_LIST    = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_DIRECT = 2'd1,
        MODE_LIST   = 2'd2
    } mode_t;

    typedef struct packed {
        logic             st;
        logic [AW-1:0]    base;
        logic [AW-1:0]    prp1_addr;
        logic [AW-1:0]    addr;
        logic [LEN_W-1:0] len;
        logic [SZ_W-1:0]  chunk0;
        logic             fin0;
        logic [31:0]      rem_nx;
        logic             last_prp1;
        logic [PS_W-1:0]  ps;
    } job_t;

    typedef struct packed {
        kind_t            kind;
        logic [63:0]      entry_addr;
        logic [IDX_W-1:0] list_index;
        logic [31:0]      processed_bytes;
        mode_t            prp2_mode;
        logic             split;
        logic             element_consumed;
        logic             last;
    } result_t;

endpackage

// File: hw/rtl/sgp_front.sv
`timescale 1ns / 1ps

module sgp_front
    import sgp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [PS_W-1:0]     cfg_wdata,
    input  logic                start_command,
    input  logic [31:0]         remaining_bytes,
    input  logic [63:0]         list_base_addr,
    input  logic [63:0]         elem_addr,
    input  logic [IN_LEN_W-1:0] elem_len,
    output job_t                job
);

    logic [PS_W-1:0]  page_shift_reg;
    logic [PS_W-1:0]  ps;
    logic [AW-1:0]    pm;
    logic [PG_W-1:0]  pg;
    logic [PG_W-1:0]  span;
    logic [AW-1:0]    addr;
    logic [LEN_W-1:0] len_c;
    logic [SZ_W-1:0]  chunk0;
    logic [AW-1:0]    addr_after;
    logic [LEN_W-1:0] len_after;
    logic             fin0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_shift_reg <= PS_W'(PS_RESET);
        end
        else if (cfg_we)
        begin
            page_shift_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (page_shift_reg inside {[PS_MIN:PS_MAX]})
        begin
            ps = page_shift_reg;
        end
        else if (page_shift_reg < PS_W'(PS_MIN))
        begin
            ps = PS_W'(PS_MIN);
        end
        else
        begin
            ps = PS_W'(PS_MAX);
        end
    end

    always_comb
    begin
        addr = AW'(elem_addr);
        pm   = (AW'(1) << ps) - AW'(1);
        pg   = PG_W'(1) << ps;
        span = pg - PG_W'(addr & pm);

        if (LEN_CMP_W'(elem_len) > LEN_CMP_W'(MAX_ELEM_BYTES))
        begin
            len_c = LEN_W'(MAX_ELEM_BYTES);
        end
        else
        begin
            len_c = LEN_W'(elem_len);
        end

        if (SZ_W'(len_c) < SZ_W'(span))
        begin
            chunk0 = SZ_W'(len_c);
        end
        else
        begin
            chunk0 = SZ_W'(span);
        end

        fin0       = 32'(chunk0) >= remaining_bytes;
        addr_after = addr + AW'(chunk0);
        len_after  = len_c - LEN_W'(chunk0);

        job.st        = start_command;
        job.base      = AW'(list_base_addr);
        job.prp1_addr = addr;
        job.addr      = start_command ? addr_after : addr;
        job.len       = start_command ? len_after : len_c;
        job.chunk0    = chunk0;
        job.fin0      = fin0;
        job.rem_nx    = remaining_bytes - 32'(chunk0);
        job.last_prp1 = !fin0 && (len_after == '0) && ((addr_after & pm) == '0);
        job.ps        = ps;
    end

endmodule

// File: hw/rtl/sgp_job_q.sv
`timescale 1ns / 1ps

module sgp_job_q
    import sgp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t job_in,
    output logic full,
    output logic valid,
    input  logic pop,
    output job_t job_out
);

    job_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign job_out = mem_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= !rp_reg;
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// File: hw/rtl/sgp_back.sv
`timescale 1ns / 1ps

module sgp_back
    import sgp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    input  job_t    job,
    output logic    job_pop,
    output logic    empty,
    input  logic    pop,
    output result_t head
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic             active_reg, active_next;
    logic [31:0]      remaining_reg, remaining_next;
    logic [31:0]      processed_reg, processed_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]    first_reg, first_next;
    logic [AW-1:0]    lptr_reg, lptr_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [PS_W-1:0]  ps_reg, ps_next;
    logic             cons_reg, cons_next;
    logic             sum_split_reg, sum_split_next;
    logic             sum_cons_reg, sum_cons_next;
    logic             sum_inlist_reg, sum_inlist_next;

    result_t          rq_mem_reg [2];
    logic             rq_wp_reg;
    logic             rq_rp_reg;
    logic [1:0]       rq_cnt_reg;
    logic             rq_room;
    logic             rq_pop;

    logic             emit_valid;
    result_t          emit;

    logic [AW-1:0]    pm;
    logic [PG_W-1:0]  pg;
    logic [SZ_W-1:0]  chunk;
    logic [LEN_W-1:0] len_nx;
    logic [AW-1:0]    addr_nx;
    logic [32:0]      proc_sum;
    logic [31:0]      proc_sat;
    logic             chunk_ge;
    logic             entry_last;

    assign rq_room = (rq_cnt_reg != 2'd2);
    assign empty   = (rq_cnt_reg == 2'd0);
    assign head    = rq_mem_reg[rq_rp_reg];
    assign rq_pop  = pop && !empty;

    always_comb
    begin
        pm       = (AW'(1) << ps_reg) - AW'(1);
        pg       = PG_W'(1) << ps_reg;
        chunk    = (SZ_W'(len_reg) < SZ_W'(pg)) ? SZ_W'(len_reg) : SZ_W'(pg);
        len_nx   = len_reg - LEN_W'(chunk);
        addr_nx  = addr_reg + AW'(chunk);
        proc_sum = {1'b0, processed_reg} + 33'(chunk);
        proc_sat = proc_sum[32] ? '1 : proc_sum[31:0];
        chunk_ge = 32'(chunk) >= remaining_reg;
        entry_last = !chunk_ge && (len_nx == '0) && ((addr_nx & pm) == '0);
    end

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        remaining_next  = remaining_reg;
        processed_next  = processed_reg;
        count_next      = count_reg;
        first_next      = first_reg;
        lptr_next       = lptr_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        ps_next         = ps_reg;
        cons_next       = cons_reg;
        sum_split_next  = sum_split_reg;
        sum_cons_next   = sum_cons_reg;
        sum_inlist_next = sum_inlist_reg;
        job_pop         = 1'b0;
        emit_valid      = 1'b0;

        emit.kind             = KIND_LIST;
        emit.entry_addr       = 64'(addr_reg);
        emit.list_index       = IDX_W'(count_reg);
        emit.processed_bytes  = '0;
        emit.prp2_mode        = MODE_NONE;
        emit.split            = 1'b0;
        emit.element_consumed = 1'b1;
        emit.last             = entry_last;

        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid && rq_room)
                begin
                    job_pop   = 1'b1;
                    addr_next = job.addr;
                    len_next  = job.len;
                    ps_next   = job.ps;
                    if (job.st)
                    begin
                        emit_valid      = 1'b1;
                        emit.kind       = KIND_PRP1;
                        emit.entry_addr = 64'(job.prp1_addr);
                        emit.list_index = '0;
                        emit.last       = job.last_prp1;
                        processed_next  = 32'(job.chunk0);
                        count_next      = '0;
                        first_next      = '0;
                        lptr_next       = job.base;
                        cons_next       = 1'b1;
                        if (job.fin0)
                        begin
                            remaining_next  = '0;
                            active_next     = 1'b0;
                            sum_split_next  = 1'b0;
                            sum_cons_next   = 1'b1;
                            sum_inlist_next = 1'b0;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            remaining_next = job.rem_nx;
                            active_next    = 1'b1;
                            state_next     = ST_WALK;
                        end
                    end
                    else if (active_reg)
                    begin
                        cons_next  = 1'b0;
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                if (rq_room)
                begin
                    if ((addr_reg & pm) != '0)
                    begin
                        sum_split_next  = 1'b1;
                        sum_cons_next   = cons_reg;
                        sum_inlist_next = 1'b1;
                        state_next      = ST_DONE;
                    end
                    else if (len_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (count_reg >= CNT_W'(LIST_ENTRIES))
                    begin
                        sum_split_next  = 1'b1;
                        sum_cons_next   = cons_reg;
                        sum_inlist_next = 1'b1;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        emit_valid = 1'b1;
                        if (count_reg == '0)
                        begin
                            first_next = addr_reg;
                        end
                        count_next     = count_reg + CNT_W'(1);
                        processed_next = proc_sat;
                        addr_next      = addr_nx;
                        len_next       = len_nx;
                        cons_next      = 1'b1;
                        if (chunk_ge)
                        begin
                            remaining_next  = '0;
                            sum_split_next  = 1'b0;
                            sum_cons_next   = 1'b1;
                            sum_inlist_next = 1'b1;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            remaining_next = remaining_reg - 32'(chunk);
                        end
                    end
                end
            end

            ST_DONE:
            begin
                emit.kind             = KIND_SUMMARY;
                emit.list_index       = '0;
                emit.processed_bytes  = processed_reg;
                emit.split            = sum_split_reg;
                emit.element_consumed = sum_cons_reg;
                emit.last             = 1'b1;
                if (sum_inlist_reg && (count_reg == CNT_W'(1)))
                begin
                    emit.prp2_mode  = MODE_DIRECT;
                    emit.entry_addr = 64'(first_reg);
                end
                else if (sum_inlist_reg && (count_reg > CNT_W'(1)))
                begin
                    emit.prp2_mode  = MODE_LIST;
                    emit.entry_addr = 64'(lptr_reg);
                end
                else
                begin
                    emit.prp2_mode  = MODE_NONE;
                    emit.entry_addr = '0;
                end
                if (rq_room)
                begin
                    emit_valid  = 1'b1;
                    active_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= 1'b0;
            remaining_reg  <= '0;
            processed_reg  <= '0;
            count_reg      <= '0;
            first_reg      <= '0;
            lptr_reg       <= '0;
            addr_reg       <= '0;
            len_reg        <= '0;
            ps_reg         <= PS_W'(PS_RESET);
            cons_reg       <= 1'b0;
            sum_split_reg  <= 1'b0;
            sum_cons_reg   <= 1'b0;
            sum_inlist_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            remaining_reg  <= remaining_next;
            processed_reg  <= processed_next;
            count_reg      <= count_next;
            first_reg      <= first_next;
            lptr_reg       <= lptr_next;
            addr_reg       <= addr_next;
            len_reg        <= len_next;
            ps_reg         <= ps_next;
            cons_reg       <= cons_next;
            sum_split_reg  <= sum_split_next;
            sum_cons_reg   <= sum_cons_next;
            sum_inlist_reg <= sum_inlist_next;
        end
    end

    // hold results until taken
    always_ff @(posedge clk)
    begin
        if (emit_valid)
        begin
            rq_mem_reg[rq_wp_reg] <= emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wp_reg  <= 1'b0;
            rq_rp_reg  <= 1'b0;
            rq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (emit_valid)
            begin
                rq_wp_reg <= !rq_wp_reg;
            end
            if (rq_pop)
            begin
                rq_rp_reg <= !rq_rp_reg;
            end
            case ({emit_valid, rq_pop})
                2'b10:   rq_cnt_reg <= rq_cnt_reg + 2'd1;
                2'b01:   rq_cnt_reg <= rq_cnt_reg - 2'd1;
                default: rq_cnt_reg <= rq_cnt_reg;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid |-> (rq_cnt_reg != 2'd2))
        else $error("result pushed into full queue");

    a_walk_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> active_reg)
        else $error("walking a list with no open command");

    a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_valid && (emit.kind == KIND_LIST)) |-> (count_reg < CNT_W'(LIST_ENTRIES)))
        else $error("list entry beyond list size");

    a_summary_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_valid && (emit.kind == KIND_SUMMARY)) |=> !active_reg)
        else $error("command still open after summary");

endmodule

// File: hw/rtl/sg_to_prp_list_builder_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake         Payload
// request   in         push / full       start_command remaining_bytes list_base_addr
//                                        elem_addr elem_len
// result    out        empty / pop       kind entry_addr list_index processed_bytes
//                                        prp2_mode split element_consumed last
// config    in         cfg_we            cfg_wdata (page_shift)
//
// A request is registered into the job queue. The back sequencer picks it up (emitting PRP1
// on a start), then emits one result per list entry and one per summary; a walk that runs
// out of data or ends split first passes a check step that emits nothing.
// Reset returns to idle with page_shift 12; no clearing pass.
// The job queue holds two requests; the result queue holds two results and stalls
// the sequencer when full.

module sg_to_prp_list_builder_unit
    import sgp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                start_command,
    input  logic [31:0]         remaining_bytes,
    input  logic [63:0]         list_base_addr,
    input  logic [63:0]         elem_addr,
    input  logic [IN_LEN_W-1:0] elem_len,
    input  logic                cfg_we,
    input  logic [PS_W-1:0]     cfg_wdata,
    output logic                empty,
    input  logic                pop,
    output logic [1:0]          kind,
    output logic [63:0]         entry_addr,
    output logic [IDX_W-1:0]    list_index,
    output logic [31:0]         processed_bytes,
    output logic [1:0]          prp2_mode,
    output logic                split,
    output logic                element_consumed,
    output logic                last
);

    job_t    front_job;
    job_t    back_job;
    logic    job_valid;
    logic    job_pop;
    result_t head;

    sgp_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .start_command   (start_command),
        .remaining_bytes (remaining_bytes),
        .list_base_addr  (list_base_addr),
        .elem_addr       (elem_addr),
        .elem_len        (elem_len),
        .job             (front_job)
    );

    sgp_job_q u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (front_job),
        .full    (full),
        .valid   (job_valid),
        .pop     (job_pop),
        .job_out (back_job)
    );

    sgp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (back_job),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .head      (head)
    );

    assign kind             = head.kind;
    assign entry_addr       = head.entry_addr;
    assign list_index       = head.list_index;
    assign processed_bytes  = head.processed_bytes;
    assign prp2_mode        = head.prp2_mode;
    assign split            = head.split;
    assign element_consumed = head.element_consumed;
    assign last             = head.last;

endmodule
